FILE: rtl/cdfbs_pkg.sv
// Shared types and constants for the two-level CDF table binary search block.
package cdfbs_pkg;

  localparam int VAL_W       = 32;
  localparam int ENTRY_IDX_W = 15;
  localparam int COL_OUT_W   = 8;
  localparam int ROW_OUT_W   = 7;
  localparam int CFG_WIDTH_W = 9;
  localparam int CFG_HEIGHT_W = 8;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 9'd256;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_IN_USE  = 1'b0,
    REG_HEIGHT_IN_USE = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SEARCH = 1'b1
  } req_type_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_PROBE,
    ST_ROW_CMP,
    ST_COL_PROBE,
    ST_COL_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic start_row;
    logic start_col;
    logic step;
    logic load_out;
    logic col_phase;
  } cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
  } status_t;

endpackage

FILE: rtl/cdfbs_ctrl.sv
// Controller state machine that sequences table loads and the two search phases.
module cdfbs_ctrl
  import cdfbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_req_type,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == REQ_SEARCH) begin
            cmd.start_row = 1'b1;
            state_nxt     = ST_ROW_PROBE;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_ROW_PROBE: begin
        if (status.lo_lt_hi) begin
          state_nxt = ST_ROW_CMP;
        end else begin
          cmd.start_col = 1'b1;
          state_nxt     = ST_COL_PROBE;
        end
      end
      ST_ROW_CMP: begin
        cmd.step  = 1'b1;
        state_nxt = ST_ROW_PROBE;
      end
      ST_COL_PROBE: begin
        cmd.col_phase = 1'b1;
        if (status.lo_lt_hi) begin
          state_nxt = ST_COL_CMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_COL_CMP: begin
        cmd.col_phase = 1'b1;
        cmd.step      = 1'b1;
        state_nxt     = ST_COL_PROBE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/cdfbs_dpath.sv
// Datapath with the table memory, search bounds, probe address unit and result register.
module cdfbs_dpath
  import cdfbs_pkg::*;
#(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [VAL_W-1:0]       in_entry_value,
  input  logic [VAL_W-1:0]       in_search_value,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic [COL_OUT_W-1:0]   out_col_index,
  output logic [ROW_OUT_W-1:0]   out_row_index
);

  localparam int FULL_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int IDX_SPACE  = 2 ** ENTRY_IDX_W;
  localparam int DEPTH      = (FULL_DEPTH < IDX_SPACE) ? FULL_DEPTH : IDX_SPACE;
  localparam int AW         = $clog2(DEPTH);
  localparam int RW         = $clog2(MAX_ROWS);
  localparam int CWI        = $clog2(MAX_COLS);
  localparam int IW         = (RW > CWI) ? RW : CWI;
  localparam int WW         = $clog2(MAX_COLS + 1);
  localparam int HW         = $clog2(MAX_ROWS + 1);
  localparam int PW         = IW + WW;

  logic [CFG_WIDTH_W-1:0]  width_r;
  logic [CFG_HEIGHT_W-1:0] height_r;
  logic [WW-1:0]           w_eff;
  logic [HW-1:0]           h_eff;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;
  logic [VAL_W-1:0] value_r;
  logic [IW-1:0]    lo_r;
  logic [IW-1:0]    hi_r;
  logic [RW-1:0]    row_r;
  logic [COL_OUT_W-1:0] col_out_r;
  logic [ROW_OUT_W-1:0] row_out_r;

  logic [IW:0]   sum;
  logic [IW-1:0] mid;
  logic [IW-1:0] mul_a;
  logic [PW-1:0] product;
  logic [PW:0]   addr_full;
  logic [PW:0]   offset;
  logic [AW-1:0] rd_addr;
  logic          wr_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH_IN_USE:  width_r  <= cfg_wdata;
        REG_HEIGHT_IN_USE: height_r <= CFG_HEIGHT_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > MAX_COLS) begin
      w_eff = WW'(MAX_COLS);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_r) > MAX_ROWS) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = HW'(height_r);
    end
  end

  assign sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid  = sum[IW:1];
  assign mul_a = cmd.col_phase ? IW'(row_r) : mid;
  assign product = PW'(mul_a) * PW'(w_eff);
  assign offset = cmd.col_phase ? (PW + 1)'(mid) : (PW + 1)'(w_eff - WW'(1));
  assign addr_full = {1'b0, product} + offset;
  assign rd_addr = addr_full[AW-1:0];
  assign wr_ok = 32'(in_entry_index) < DEPTH;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem[in_entry_index[AW-1:0]] <= in_entry_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start_row) begin
      value_r <= in_search_value;
      lo_r    <= '0;
      hi_r    <= IW'(h_eff - HW'(1));
    end else if (cmd.start_col) begin
      row_r <= lo_r[RW-1:0];
      lo_r  <= '0;
      hi_r  <= IW'(w_eff - WW'(1));
    end else if (cmd.step) begin
      if (value_r < rd_data_r) begin
        hi_r <= mid;
      end else begin
        lo_r <= mid + IW'(1);
      end
    end
    if (cmd.load_out) begin
      col_out_r <= COL_OUT_W'(lo_r);
      row_out_r <= ROW_OUT_W'(row_r);
    end
  end

  assign status.lo_lt_hi = lo_r < hi_r;
  assign out_col_index   = col_out_r;
  assign out_row_index   = row_out_r;

endmodule

FILE: rtl/cdf_table_2d_binary_search_top.sv
// Top level of the two-level inverse CDF table binary search block.
//
// The input channel carries one request per transfer. A load request writes
// in_entry_value into the table at flat index in_entry_index in the cycle it
// is accepted and produces no result. A search request locates the first row
// whose last entry exceeds in_search_value, then the first column of that row
// whose entry exceeds it, and returns the column and row on the output channel.
// A search makes one table read and one compare for each binary search probe
// on the single read port. Loads can be taken every cycle while the block is
// idle. The next request is taken in the cycle after a search result is
// written, so a new search is not taken before the last one completes. The
// result sits in an output register; while the receiver stalls it holds,
// and new requests are taken until the next search result is ready to be
// written into that register. Reset is synchronous; it empties the output
// register and returns the in-use width and height to 256 and 128. The table
// contents are undefined until written. Configuration writes take effect at
// once; the user must make them only while the block is idle, as the block
// itself does not enforce it.
module cdf_table_2d_binary_search_top
  import cdfbs_pkg::*;
#(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_req_type,
  input  logic [ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [VAL_W-1:0]       in_entry_value,
  input  logic [VAL_W-1:0]       in_search_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COL_OUT_W-1:0]   out_col_index,
  output logic [ROW_OUT_W-1:0]   out_row_index
);

  cmd_t    cmd;
  status_t status;

  cdfbs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .cmd         (cmd)
  );

  cdfbs_dpath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_search_value (in_search_value),
    .cmd             (cmd),
    .status          (status),
    .out_col_index   (out_col_index),
    .out_row_index   (out_row_index)
  );

endmodule

FILE: rtl/cdfbs_checker.sv
// Port-level checker for the CDF table search block and its bind to the top level.
module cdfbs_checker
  import cdfbs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_req_type,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [COL_OUT_W-1:0] out_col_index,
  input logic [ROW_OUT_W-1:0] out_row_index
);

  a_reset_empties_output: assert property (
    @(posedge clk) !rst_n |=> !out_valid
  ) else $error("output valid after reset");

  a_stalled_result_holds: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_col_index) && $stable(out_row_index)
  ) else $error("stalled result changed or dropped");

  a_load_gives_no_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_LOAD) |=> !$rose(out_valid) && in_ready
  ) else $error("load transfer produced a result or blocked input");

  a_search_busy: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_SEARCH) |=> !in_ready && !$rose(out_valid)
  ) else $error("search transfer did not occupy the block");

  a_result_frees_input: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $rose(in_ready)
  ) else $error("result appeared without the block going idle");

endmodule

bind cdf_table_2d_binary_search_top cdfbs_checker u_cdfbs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_req_type   (in_req_type),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_col_index (out_col_index),
  .out_row_index (out_row_index)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-level CDF table binary search block.
module tb_top;
  import cdfbs_pkg::*;

  localparam int MAX_COLS      = 256;
  localparam int MAX_ROWS      = 128;
  localparam int TABLE_DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct packed {
    req_type_t              kind;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [VAL_W-1:0]       entry_val;
    logic [VAL_W-1:0]       probe_val;
  } cdf_req_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
  } cdf_hit_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_req_type = 1'b0;
  logic [ENTRY_IDX_W-1:0] in_entry_index = '0;
  logic [VAL_W-1:0]       in_entry_value = '0;
  logic [VAL_W-1:0]       in_search_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [COL_OUT_W-1:0]   out_col_index;
  logic [ROW_OUT_W-1:0]   out_row_index;

  cdf_req_t               pending_reqs[$];
  cdf_hit_t               expected_hits[$];
  logic [VAL_W-1:0]       table_plan[$];
  logic [VAL_W-1:0]       cdf_mirror[TABLE_DEPTH];
  logic [CFG_WIDTH_W-1:0] width_reg = WIDTH_RESET;
  logic [CFG_HEIGHT_W-1:0] height_reg = HEIGHT_RESET;

  int fail_count = 0;
  int cycle_count = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  cdf_table_2d_binary_search_top #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_entry_index(in_entry_index),
    .in_entry_value(in_entry_value),
    .in_search_value(in_search_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_col_index(out_col_index),
    .out_row_index(out_row_index)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(int unsigned raw, int unsigned top);
    if (raw < 1) return 1;
    if (raw > top) return top;
    return raw;
  endfunction

  function automatic int unsigned first_above(logic [VAL_W-1:0] v, int unsigned n,
                                              int unsigned base, int unsigned stride);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (v < cdf_mirror[base + mid * stride]) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic void absorb_request(cdf_req_t r);
    int unsigned w;
    int unsigned h;
    int unsigned row;
    int unsigned col;
    cdf_hit_t    hit;
    if (r.kind == REQ_LOAD) begin
      cdf_mirror[r.idx] = r.entry_val;
    end else begin
      w = clamp_dim(width_reg, MAX_COLS);
      h = clamp_dim(height_reg, MAX_ROWS);
      row = first_above(r.probe_val, h, w - 1, w);
      col = first_above(r.probe_val, w, row * w, 1);
      hit.col = col[COL_OUT_W-1:0];
      hit.row = row[ROW_OUT_W-1:0];
      expected_hits.push_back(hit);
    end
  endfunction

  function automatic logic [VAL_W-1:0] pick_probe();
    logic [VAL_W-1:0] v;
    v = table_plan[$urandom_range(0, table_plan.size() - 1)];
    case ($urandom_range(0, 7))
      0: v = $urandom();
      1: v = '0;
      2: v = $urandom() | 32'h8000_0000;
      3, 4: ;
      5: v = v - 1;
      6: v = v + 1;
      default: v = table_plan[table_plan.size() - 1];
    endcase
    return v;
  endfunction

  task automatic push_load(int unsigned idx, logic [VAL_W-1:0] val);
    cdf_req_t r;
    r.kind = REQ_LOAD;
    r.idx = idx[ENTRY_IDX_W-1:0];
    r.entry_val = val;
    r.probe_val = $urandom();
    pending_reqs.push_back(r);
  endtask

  task automatic push_search(logic [VAL_W-1:0] v);
    cdf_req_t r;
    r.kind = REQ_SEARCH;
    r.idx = ENTRY_IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    r.entry_val = $urandom();
    r.probe_val = v;
    pending_reqs.push_back(r);
  endtask

  task automatic set_shape(int unsigned w_raw, int unsigned h_raw);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH_IN_USE;
    cfg_wdata <= w_raw[CFG_DATA_W-1:0];
    width_reg = w_raw[CFG_WIDTH_W-1:0];
    @(posedge clk);
    cfg_index <= REG_HEIGHT_IN_USE;
    cfg_wdata <= h_raw[CFG_DATA_W-1:0];
    height_reg = h_raw[CFG_HEIGHT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_hits.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic fill_table(int unsigned n);
    int unsigned      i;
    logic [VAL_W-1:0] v;
    table_plan.delete();
    v = $urandom_range(0, 32'h3F80_0000);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: ;
        1: v += $urandom_range(1, 16);
        2: v += $urandom_range(1, 32'h1_0000);
        default: v += $urandom_range(1, 32'h10_0000);
      endcase
      table_plan.push_back(v);
      push_load(i, v);
    end
  endtask

  task automatic mixed_traffic(int unsigned n, int unsigned cells);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: push_load($urandom_range(0, TABLE_DEPTH - 1), $urandom());
        1: push_load($urandom_range(0, cells - 1), $urandom());
        default: push_search(pick_probe());
      endcase
    end
  endtask

  task automatic run_phase(int unsigned w_raw, int unsigned h_raw, int unsigned n,
                           bit squeeze);
    int unsigned cells;
    drain();
    set_shape(w_raw, h_raw);
    cells = clamp_dim(width_reg, MAX_COLS) * clamp_dim(height_reg, MAX_ROWS);
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    fill_table(cells);
    if (squeeze) begin
      drain();
      tx_calm = 1'b1;
      hold_ask++;
    end
    mixed_traffic(n, cells);
  endtask

  always @(posedge clk) begin : drive_seq
    cdf_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else if (!in_valid || in_ready) begin
      if (tx_wait > 0) begin
        tx_wait <= tx_wait - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_req_type <= r.kind;
        in_entry_index <= r.idx;
        in_entry_value <= r.entry_val;
        in_search_value <= r.probe_val;
        tx_wait <= tx_calm ? 0 : $urandom_range(0, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : take_seq
    int unsigned pause;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      rx_wait <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      pause = rx_calm ? 0 : $urandom_range(0, 11);
      rx_wait <= pause;
      out_ready <= (pause == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_seq
    cdf_hit_t want;
    cdf_req_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected transfer: col_index %0d row_index %0d",
                 out_col_index, out_row_index);
          fail_count++;
        end else begin
          want = expected_hits.pop_front();
          if (out_col_index !== want.col) begin
            $error("col_index: expected %0d, actual %0d", want.col, out_col_index);
            fail_count++;
          end
          if (out_row_index !== want.row) begin
            $error("row_index: expected %0d, actual %0d", want.row, out_row_index);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        got.kind = req_type_t'(in_req_type);
        got.idx = in_entry_index;
        got.entry_val = in_entry_value;
        got.probe_val = in_search_value;
        absorb_request(got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // A three by two table with a zero entry and a repeated entry.
    set_shape(3, 2);
    push_load(0, 32'h0000_0000);
    push_load(1, 32'h3E80_0000);
    push_load(2, 32'h3E80_0000);
    push_load(3, 32'h3F00_0000);
    push_load(4, 32'h3F40_0000);
    push_load(5, 32'h3F80_0000);
    push_search(32'h0000_0000);
    push_search(32'h3E7F_FFFF);
    push_search(32'h3E80_0000);
    push_search(32'h3F00_0000);
    push_search(32'h3F7F_FFFF);
    push_search(32'h3F80_0000);
    push_search(32'h7F80_0000);
    push_search(32'h8000_0000);
    push_search(32'hFFFF_FFFF);
    push_load(15'h7FFF, 32'hFFFF_FFFF);
    push_load(5, 32'h7F7F_FFFF);
    push_search(32'h7F7F_FFFE);
    push_search(32'h7F7F_FFFF);

    run_phase(511, 0, 70, 1'b1);
    run_phase(0, 255, 70, 1'b0);
    run_phase(1, 1, 40, 1'b0);
    for (k = 0; k < 4; k++) begin
      run_phase($urandom_range(2, 16), $urandom_range(2, 8), 40, 1'b0);
    end
    drain();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
